[hw/rtl/rfs_pkg.sv]
// Shared types, constants and helpers for the record field splitter.
`default_nettype none

package rfs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FIELDS_DEF     = 64;
  localparam int MAX_RECORD_LEN_DEF = 65536;
  localparam int MAX_SEP_LEN_DEF    = 4;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Width used for offset arithmetic before saturation to 16 bits
  localparam int SAT_W = 25;

  // Separator bytes are looked up in a word this wide (eight bytes at most)
  localparam int SEP_VEC_W = 64;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Register select, taken from paddr[2]
  localparam logic REG_SEP_LEN   = 1'b0;
  localparam logic REG_SEP_BYTES = 1'b1;

  localparam logic [2:0]  SEP_LEN_RST   = 3'd1;
  localparam logic [31:0] SEP_BYTES_RST = 32'h0000_0020;

  typedef struct packed {
    logic [2:0]  sep_len;
    logic [31:0] sep_bytes;
  } rfs_cfg_t;

  typedef struct packed {
    logic        has_field;
    logic [5:0]  field_index;
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic        last_of_record;
    logic [5:0]  field_total;
    logic [31:0] record_number;
    logic        too_long;
  } rfs_result_t;

  typedef struct packed {
    logic nonempty;
    logic room2;
  } rfs_qstat_t;

  function automatic logic [15:0] sat16(input logic [SAT_W-1:0] v);
    sat16 = (|v[SAT_W-1:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic over16(input logic [SAT_W-1:0] v);
    over16 = |v[SAT_W-1:16];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/record_field_splitter.sv]
// A result word passes through the result queue and then the output register. Throughput:
// one byte word per cycle unless in_stall; one result word per cycle unless out_stall.
// A byte that closes a field and also ends the record gives two result words; the 4-deep
// result queue absorbs them and in_stall rises while fewer than two slots are free.
// Reset (synchronous, rst_n low): record state and counter cleared, queue and output
// emptied, separator registers back to one space (whitespace mode).
`default_nettype none

module record_field_splitter import rfs_pkg::*; #(
  parameter int MAX_FIELDS     = MAX_FIELDS_DEF,
  parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
  parameter int MAX_SEP_LEN    = MAX_SEP_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte words in
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_end_of_record,
  // field descriptor words out
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_field,
  output logic [5:0]       out_field_index,
  output logic [15:0]      out_field_start,
  output logic [15:0]      out_field_length,
  output logic             out_last_of_record,
  output logic [5:0]       out_field_total,
  output logic [31:0]      out_record_number,
  output logic             out_too_long
);

  // Separator registers: length at 0x0, bytes at 0x4 (first byte in bits 7:0).
  // Decode uses paddr[2] only, so each register is aliased within its word.
  logic [2:0]  sep_len_r;
  logic [31:0] sep_bytes_r;
  logic        wr_en;
  rfs_cfg_t    cfg;

  rfs_qstat_t  qstat;
  logic [1:0]  push_n;
  rfs_result_t push_w0, push_w1;
  rfs_result_t head;
  logic        pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SEP_BYTES) ? sep_bytes_r : {29'd0, sep_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r   <= SEP_LEN_RST;
      sep_bytes_r <= SEP_BYTES_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_SEP_LEN) sep_len_r   <= pwdata[2:0];
      else                         sep_bytes_r <= pwdata;
    end
  end

  assign cfg.sep_len   = sep_len_r;
  assign cfg.sep_bytes = sep_bytes_r;

  // Front: field tracking and separator matching, one byte per cycle while in_stall is low
  rfs_front #(
    .MAX_FIELDS     (MAX_FIELDS),
    .MAX_RECORD_LEN (MAX_RECORD_LEN),
    .MAX_SEP_LEN    (MAX_SEP_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_record (in_end_of_record),
    .qstat            (qstat),
    .push_n           (push_n),
    .push_w0          (push_w0),
    .push_w1          (push_w1)
  );

  // Queue decouples the byte side from the result side
  rfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (push_n),
    .push_w0 (push_w0),
    .push_w1 (push_w1),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  // Back: output register, refilled whenever it is empty or being taken and the queue holds a word
  rfs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .qstat              (qstat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_has_field      (out_has_field),
    .out_field_index    (out_field_index),
    .out_field_start    (out_field_start),
    .out_field_length   (out_field_length),
    .out_last_of_record (out_last_of_record),
    .out_field_total    (out_field_total),
    .out_record_number  (out_record_number),
    .out_too_long       (out_too_long)
  );

endmodule

`default_nettype wire

[hw/rtl/rfs_front.sv]
// Front end: takes record bytes, tracks field state, forms result words.
`default_nettype none

module rfs_front import rfs_pkg::*; #(
  parameter int MAX_FIELDS     = MAX_FIELDS_DEF,
  parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
  parameter int MAX_SEP_LEN    = MAX_SEP_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rfs_cfg_t    cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_end_of_record,
  input  wire rfs_qstat_t  qstat,
  output logic [1:0]       push_n,
  output rfs_result_t      push_w0,
  output rfs_result_t      push_w1
);

  localparam int IW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam int PW = $clog2(MAX_RECORD_LEN + 1);
  localparam int WB = (MAX_SEP_LEN > 1) ? MAX_SEP_LEN - 1 : 1;
  localparam int FW = (MAX_SEP_LEN > 1) ? $clog2(MAX_SEP_LEN) : 1;
  localparam int LW = $clog2(MAX_SEP_LEN + 1);
  localparam int FIELD_LIMIT = MAX_FIELDS - 1;

  logic [8*WB-1:0] win_r,    win_nxt;
  logic [FW-1:0]   fill_r,   fill_nxt;
  logic [PW-1:0]   pos_r,    pos_nxt;
  logic [PW-1:0]   cs_r,     cs_nxt;
  logic [IW-1:0]   ci_r,     ci_nxt;
  logic            inside_r, inside_nxt;
  logic            ended_r,  ended_nxt;
  logic            limit_r,  limit_nxt;
  logic            ovl_r,    ovl_nxt;
  logic [31:0]     rc_r,     rc_nxt;

  logic            accept;

  function automatic rfs_result_t mk(input logic has, input logic [IW-1:0] idx,
                                     input logic [SAT_W-1:0] start,
                                     input logic [SAT_W-1:0] len,
                                     input logic [31:0] recnum, input logic ovl);
    rfs_result_t r;
    r.has_field      = has;
    r.field_index    = 6'(idx);
    r.field_start    = sat16(start);
    r.field_length   = sat16(len);
    r.last_of_record = 1'b0;
    r.field_total    = '0;
    r.record_number  = recnum;
    r.too_long       = ovl | over16(start) | over16(len);
    return r;
  endfunction

  assign in_stall = !qstat.room2;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [LW-1:0]            n;
    logic                     ws;
    logic                     hit;
    logic [8*(WB+1)-1:0]      hv;
    logic [SEP_VEC_W-1:0]     sepv;
    logic [2:0]               sidx;
    logic [PW-1:0]            pos1;
    logic                     e_b, e_e, e_empty;
    logic [IW-1:0]            b_idx;
    logic [SAT_W-1:0]         b_start, b_len;
    logic [IW-1:0]            ci_fin;
    logic [31:0]              recnum;
    rfs_result_t              rb, re, rz;

    // Effective separator length, clamped to 1..MAX_SEP_LEN
    if (cfg.sep_len == 3'd0) begin
      n = LW'(1);
    end else if (32'(cfg.sep_len) > 32'(MAX_SEP_LEN)) begin
      n = LW'(MAX_SEP_LEN);
    end else begin
      n = LW'(cfg.sep_len);
    end
    ws = (n == LW'(1)) && (cfg.sep_bytes[7:0] == CHAR_SPACE);

    // Separator match over the incoming byte and the window
    hv   = {win_r, in_data_byte};
    sepv = SEP_VEC_W'(cfg.sep_bytes);
    hit  = (32'(fill_r) + 32'd1) >= 32'(n);
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      sidx = 3'(32'(n) - 32'd1 - 32'(i));
      if (32'(i) < 32'(n)) begin
        if (hv[8*i +: 8] != sepv[8*sidx +: 8]) hit = 1'b0;
      end
    end

    recnum  = rc_r + 32'd1;
    pos1    = pos_r + PW'(1);
    e_b     = 1'b0;
    e_e     = 1'b0;
    e_empty = 1'b0;
    b_idx   = ci_r;
    b_start = SAT_W'(cs_r);
    b_len   = '0;

    win_nxt    = win_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    cs_nxt     = cs_r;
    ci_nxt     = ci_r;
    inside_nxt = inside_r;
    ended_nxt  = ended_r;
    limit_nxt  = limit_r;
    ovl_nxt    = ovl_r;
    rc_nxt     = rc_r;

    if (in_byte_valid && !ended_r) begin
      if (in_data_byte == CHAR_NUL) begin
        ended_nxt = 1'b1;
      end else if (pos_r >= PW'(MAX_RECORD_LEN)) begin
        ovl_nxt = 1'b1;
      end else begin
        pos_nxt = pos1;
        if (ws) begin
          if (in_data_byte == CHAR_SPACE || in_data_byte == CHAR_TAB) begin
            if (inside_r) begin
              e_b        = 1'b1;
              b_len      = SAT_W'(pos_r) - SAT_W'(cs_r);
              ci_nxt     = ci_r + IW'(1);
              inside_nxt = 1'b0;
            end
          end else if (!inside_r && !limit_r) begin
            inside_nxt = 1'b1;
            cs_nxt     = pos_r;
            if (32'(ci_r) + 32'd1 >= 32'(FIELD_LIMIT)) limit_nxt = 1'b1;
          end
        end else if (32'(ci_r) + 32'd1 < 32'(FIELD_LIMIT)) begin
          if (hit) begin
            e_b      = 1'b1;
            b_len    = SAT_W'(pos1) - SAT_W'(n) - SAT_W'(cs_r);
            ci_nxt   = ci_r + IW'(1);
            cs_nxt   = pos1;
            fill_nxt = '0;
            win_nxt  = '0;
          end else begin
            win_nxt = (MAX_SEP_LEN > 1) ? (8*WB)'({win_r, in_data_byte}) : '0;
            if (32'(fill_r) < 32'(MAX_SEP_LEN - 1)) fill_nxt = fill_r + FW'(1);
          end
        end
      end
    end

    rb = mk(1'b1, b_idx, b_start, b_len, recnum, ovl_nxt);
    re = mk(1'b1, ci_nxt, SAT_W'(cs_nxt), SAT_W'(pos_nxt) - SAT_W'(cs_nxt), recnum,
            ovl_nxt);
    rz = mk(1'b0, '0, '0, '0, recnum, ovl_nxt);
    ci_fin = ci_nxt;

    if (in_end_of_record) begin
      e_e     = ws ? inside_nxt : 1'b1;
      e_empty = !e_b && !e_e;
      if (e_e) ci_fin = ci_nxt + IW'(1);
      rc_nxt     = recnum;
      win_nxt    = '0;
      fill_nxt   = '0;
      pos_nxt    = '0;
      cs_nxt     = '0;
      ci_nxt     = '0;
      inside_nxt = 1'b0;
      ended_nxt  = 1'b0;
      limit_nxt  = 1'b0;
      ovl_nxt    = 1'b0;
    end

    // Order the words: byte-completed field first, then end field or the empty marker
    push_w0 = e_b ? rb : (e_e ? re : rz);
    push_w1 = re;
    if (e_b && e_e) begin
      push_w1.last_of_record = 1'b1;
      push_w1.field_total    = 6'(ci_fin);
    end else if (in_end_of_record) begin
      push_w0.last_of_record = 1'b1;
      push_w0.field_total    = 6'(ci_fin);
    end

    push_n = accept ? (2'(e_b) + 2'(e_e) + 2'(e_empty)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      cs_r     <= '0;
      ci_r     <= '0;
      inside_r <= 1'b0;
      ended_r  <= 1'b0;
      limit_r  <= 1'b0;
      ovl_r    <= 1'b0;
      rc_r     <= '0;
    end else if (accept) begin
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      cs_r     <= cs_nxt;
      ci_r     <= ci_nxt;
      inside_r <= inside_nxt;
      ended_r  <= ended_nxt;
      limit_r  <= limit_nxt;
      ovl_r    <= ovl_nxt;
      rc_r     <= rc_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfs_queue.sv]
// Small result queue: up to two words pushed, one popped per cycle.
`default_nettype none

module rfs_queue import rfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  push_n,
  input  wire rfs_result_t push_w0,
  input  wire rfs_result_t push_w1,
  input  wire logic        pop,
  output rfs_result_t      head,
  output rfs_qstat_t       stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rfs_result_t     mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   wr1;

  assign wr1           = wr_r + AW'(1);
  assign head          = mem_r[rd_r];
  assign stat.nonempty = (count_r != '0);
  assign stat.room2    = (count_r <= CW'(DEPTH - 2));

  always_comb begin
    wr_nxt    = wr_r + AW'(push_n);
    rd_nxt    = pop ? rd_r + AW'(1) : rd_r;
    count_nxt = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= push_w0;
    if (push_n == 2'd2) mem_r[wr1]  <= push_w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH) else $error("result queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty result queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> stat.room2) else $error("push without room");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd0 && !pop) |=> $stable(count_r)) else $error("queue count drifted");

endmodule

`default_nettype wire

[hw/rtl/rfs_back.sv]
// Back end: moves queued result words into the output register.
`default_nettype none

module rfs_back import rfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rfs_result_t head,
  input  wire rfs_qstat_t  qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_field,
  output logic [5:0]       out_field_index,
  output logic [15:0]      out_field_start,
  output logic [15:0]      out_field_length,
  output logic             out_last_of_record,
  output logic [5:0]       out_field_total,
  output logic [31:0]      out_record_number,
  output logic             out_too_long
);

  logic        valid_r, valid_nxt;
  rfs_result_t word_r;

  assign pop = qstat.nonempty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop)             valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) word_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  assign out_valid          = valid_r;
  assign out_has_field      = word_r.has_field;
  assign out_field_index    = word_r.field_index;
  assign out_field_start    = word_r.field_start;
  assign out_field_length   = word_r.field_length;
  assign out_last_of_record = word_r.last_of_record;
  assign out_field_total    = word_r.field_total;
  assign out_record_number  = word_r.record_number;
  assign out_too_long       = word_r.too_long;

endmodule

`default_nettype wire
